// ===== rtl/ewt_pkg.sv =====
// shared types and codes of the event waiter table
`default_nettype none
package ewt_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_SIGNAL = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FAIL   = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;

  typedef struct packed {
    op_t         op;
    logic [3:0]  owner;
    logic [3:0]  waiter;
    logic [7:0]  priority_req;
    logic [31:0] events;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic       full_flag;
    logic       woken_valid;
    logic [3:0] woken_waiter;
    logic       top_valid;
    logic [7:0] top_priority;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_WALK,
    S_FIN,
    S_EMIT
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/event_waiter_table.sv =====
// event waiter table: per-owner waiter lists with event wakeup and top priority
// Each owner keeps its waiters packed in arrival order in one entry ram (one
// row of WAITERS entries per owner); a second small ram holds the waiter count
// of each owner, with a valid bit per owner cleared at reset so no clearing
// pass is needed. Every word for an in-range owner walks its stored entries
// once, one entry per cycle through the ram read port, rewriting the survivors
// compacted in place and tracking the minimum priority; add appends after the
// walk. The walk reads the entries, drains the last read and then sees the walk
// done. Signal emits one result word per woken waiter in arrival order. Owners
// out of range skip the walk and answer with an empty result. A new word is
// taken once the last result of the previous one sits in the output register.
`default_nettype none
module event_waiter_table
  import ewt_pkg::*;
#(
  parameter int WAITERS   = 16,
  parameter int OWNERS    = 16,
  parameter int PRIO_BITS = 8,
  parameter int MASK_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  localparam int SW   = $clog2(WAITERS);
  localparam int CW   = $clog2(WAITERS + 1);
  localparam int OW   = (OWNERS > 1) ? $clog2(OWNERS) : 1;
  localparam int EW   = 4 + PRIO_BITS + MASK_BITS;
  localparam int EDEP = 2 ** (OW + SW);
  localparam int CDEP = 2 ** OW;

  state_e state_q, state_d;

  in_word_t               item_q, item_d;
  logic [OW-1:0]          own_q, own_d;
  logic [CW-1:0]          n_q, n_d;
  logic [CW-1:0]          rd_q, rd_d;
  logic [CW-1:0]          wr_q, wr_d;
  logic                   pend_q, pend_d;
  logic                   dup_q, dup_d;
  logic                   found_q, found_d;
  logic                   minv_q, minv_d;
  logic [PRIO_BITS-1:0]   min_q, min_d;
  logic [3:0]             wq_q [WAITERS];
  logic [3:0]             wq_d [WAITERS];
  logic [CW-1:0]          wcnt_q, wcnt_d;
  status_t                st_q, st_d;
  logic                   full_q, full_d;
  logic [OWNERS-1:0]      cvld_q, cvld_d;
  out_word_t              out_q, out_d;
  logic                   ovalid_q, ovalid_d;

  // entry ram ports
  logic                   e_we, e_re;
  logic [OW+SW-1:0]       e_waddr, e_raddr;
  logic [EW-1:0]          e_wdata, e_rdata;
  // count ram ports
  logic                   c_we, c_re;
  logic [OW-1:0]          c_waddr, c_raddr;
  logic [CW-1:0]          c_wdata, c_rdata;

  ewt_ram #(.WIDTH(EW), .DEPTH(EDEP)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .re_i   (e_re),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  ewt_ram #(.WIDTH(CW), .DEPTH(CDEP)) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .re_i   (c_re),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  // fields of the entry coming out of the ram
  logic [3:0]           e_wtr;
  logic [PRIO_BITS-1:0] e_prio;
  logic [MASK_BITS-1:0] e_mask;
  assign e_mask = e_rdata[MASK_BITS-1:0];
  assign e_prio = e_rdata[MASK_BITS +: PRIO_BITS];
  assign e_wtr  = e_rdata[EW-1 -: 4];

  // new entry from the captured word
  logic [PRIO_BITS-1:0] new_prio;
  logic [MASK_BITS-1:0] new_mask;
  assign new_prio = PRIO_BITS'(item_q.priority_req);
  assign new_mask = MASK_BITS'(item_q.events);

  logic in_oor;
  assign in_oor = 32'(in_data_i.owner) >= OWNERS;

  logic walk_done, rd_more, load_out, drop;
  assign rd_more   = rd_q < n_q;
  assign walk_done = !pend_q && !rd_more;
  assign load_out  = (state_q == S_EMIT) && (!ovalid_q || !out_stall_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = in_oor ? S_EMIT : S_CNT;
        end
      end
      S_CNT:  state_d = S_WALK;
      S_WALK: begin
        if (walk_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN:  state_d = S_EMIT;
      S_EMIT: begin
        if (load_out && wcnt_q <= CW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    logic [CW-1:0] new_cnt;
    item_d   = item_q;
    own_d    = own_q;
    n_d      = n_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    pend_d   = 1'b0;
    dup_d    = dup_q;
    found_d  = found_q;
    minv_d   = minv_q;
    min_d    = min_q;
    wq_d     = wq_q;
    wcnt_d   = wcnt_q;
    st_d     = st_q;
    full_d   = full_q;
    cvld_d   = cvld_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && out_stall_i;
    e_we     = 1'b0;
    e_re     = 1'b0;
    e_waddr  = {own_q, wr_q[SW-1:0]};
    e_raddr  = {own_q, rd_q[SW-1:0]};
    e_wdata  = e_rdata;
    c_we     = 1'b0;
    c_re     = 1'b0;
    c_waddr  = own_q;
    c_raddr  = OW'(in_data_i.owner);
    c_wdata  = wr_q;
    drop     = 1'b0;
    new_cnt  = wr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          own_d  = OW'(in_data_i.owner);
          c_re   = 1'b1;
          // out of range owner answers with an empty, ok result
          st_d   = ST_OK;
          full_d = 1'b0;
          minv_d = 1'b0;
          min_d  = '0;
          wcnt_d = '0;
        end
      end
      S_CNT: begin
        n_d     = cvld_q[own_q] ? c_rdata : '0;
        rd_d    = '0;
        wr_d    = '0;
        dup_d   = 1'b0;
        found_d = 1'b0;
        minv_d  = 1'b0;
      end
      S_WALK: begin
        if (rd_more) begin
          e_re   = 1'b1;
          rd_d   = rd_q + CW'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          case (item_q.op)
            OP_ADD:    drop = 1'b0;
            OP_REMOVE: drop = (e_wtr == item_q.waiter);
            OP_SIGNAL: drop = |(e_mask & new_mask);
            default:   drop = 1'b0;
          endcase
          if (item_q.op == OP_ADD && e_wtr == item_q.waiter) begin
            dup_d = 1'b1;
          end
          if (drop) begin
            found_d = 1'b1;
            if (item_q.op == OP_SIGNAL) begin
              wq_d[wcnt_q[SW-1:0]] = e_wtr;
              wcnt_d = wcnt_q + CW'(1);
            end
          end else begin
            // survivor goes back compacted
            e_we = 1'b1;
            wr_d = wr_q + CW'(1);
            if (!minv_q || e_prio < min_q) begin
              min_d = e_prio;
            end
            minv_d = 1'b1;
          end
        end
      end
      S_FIN: begin
        st_d   = ST_OK;
        full_d = 1'b0;
        case (item_q.op)
          OP_ADD: begin
            if (dup_q) begin
              st_d = ST_FAIL;
            end else if (n_q == CW'(WAITERS)) begin
              st_d   = ST_FAIL;
              full_d = 1'b1;
            end else begin
              e_we    = 1'b1;
              e_wdata = {item_q.waiter, new_prio, new_mask};
              new_cnt = wr_q + CW'(1);
              if (!minv_q || new_prio < min_q) begin
                min_d = new_prio;
              end
              minv_d = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (!found_q) begin
              st_d = ST_ABSENT;
            end
          end
          default: ;
        endcase
        c_we           = 1'b1;
        c_wdata        = new_cnt;
        cvld_d[own_q]  = 1'b1;
        if (!minv_d) begin
          min_d = '0;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          ovalid_d           = 1'b1;
          out_d.top_valid    = minv_q;
          out_d.top_priority = 8'(min_q);
          if (wcnt_q == '0) begin
            out_d.status       = st_q;
            out_d.full_flag    = full_q;
            out_d.woken_valid  = 1'b0;
            out_d.woken_waiter = '0;
            out_d.last         = 1'b1;
          end else begin
            out_d.status       = ST_OK;
            out_d.full_flag    = 1'b0;
            out_d.woken_valid  = 1'b1;
            out_d.woken_waiter = wq_q[0];
            out_d.last         = (wcnt_q == CW'(1));
            // pop the head of the woken queue
            for (int k = 0; k < WAITERS - 1; k++) begin
              wq_d[k] = wq_q[k+1];
            end
            wcnt_d = wcnt_q - CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      cvld_q   <= '0;
      pend_q   <= 1'b0;
      wcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cvld_q   <= cvld_d;
      pend_q   <= pend_d;
      wcnt_q   <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    own_q   <= own_d;
    n_q     <= n_d;
    rd_q    <= rd_d;
    wr_q    <= wr_d;
    dup_q   <= dup_d;
    found_q <= found_d;
    minv_q  <= minv_d;
    min_q   <= min_d;
    wq_q    <= wq_d;
    st_q    <= st_d;
    full_q  <= full_d;
    out_q   <= out_d;
  end

  // compaction never writes ahead of the read pointer
  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (wr_q <= rd_q))
    else $error("compaction write passed read pointer");

  // woken queue never holds more than the walked entries
  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_FIN) |-> (wcnt_q <= rd_q))
    else $error("woken queue overrun");

  // a stored count never exceeds the table size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_we |-> (c_wdata <= CW'(WAITERS)))
    else $error("waiter count overflow");

  // a last result always returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && wcnt_q <= CW'(1)) |=> (state_q == S_IDLE && out_q.last))
    else $error("last result without return to idle");

endmodule
`default_nettype wire

// ===== rtl/ewt_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module ewt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_event_waiter_table.sv =====
// testbench of the event waiter table: random and directed words checked against a predictor
module tb_event_waiter_table;
  import ewt_pkg::*;

  localparam int WAITERS = 16;
  localparam int OWNERS  = 16;

  // op code with no meaning, must leave the tables alone
  localparam op_t OP_NONE = 2'd3;

  // waiter tables kept as arrival-ordered lists; priority order is derived
  typedef struct packed {
    logic [3:0]  id;
    logic [7:0]  prio;
    logic [31:0] mask;
  } entry_t;

  class wait_scoreboard;
    entry_t    tables[OWNERS][$];
    out_word_t pending[$];
    int        errors;

    // most privileged priority among the waiters of one owner
    function automatic void top_of(int o, output logic tv, output logic [7:0] tp);
      tv = tables[o].size() != 0;
      tp = 8'd0;
      foreach (tables[o][i])
        if (i == 0 || tables[o][i].prio < tp) tp = tables[o][i].prio;
    endfunction

    function automatic void note_word(in_word_t w);
      int o;
      int hit;
      logic [3:0] woken[$];
      out_word_t r;
      logic tv;
      logic [7:0] tp;
      entry_t keep[$];
      o = w.owner;
      hit = -1;
      r = '0;
      foreach (tables[o][i]) if (tables[o][i].id == w.waiter) hit = i;
      case (w.op)
        OP_ADD: begin
          if (hit >= 0) begin
            r.status = ST_FAIL;
          end else if (tables[o].size() >= WAITERS) begin
            r.status = ST_FAIL;
            r.full_flag = 1'b1;
          end else begin
            tables[o].push_back('{w.waiter, w.priority_req, w.events});
          end
        end
        OP_REMOVE: begin
          if (hit < 0) r.status = ST_ABSENT;
          else tables[o].delete(hit);
        end
        OP_SIGNAL: begin
          foreach (tables[o][i]) begin
            if ((tables[o][i].mask & w.events) != 0) woken.push_back(tables[o][i].id);
            else keep.push_back(tables[o][i]);
          end
          tables[o] = keep;
        end
        default: ;
      endcase
      top_of(o, tv, tp);
      r.top_valid = tv;
      r.top_priority = tp;
      if (woken.size() == 0) begin
        r.last = 1'b1;
        pending.push_back(r);
      end else begin
        foreach (woken[k]) begin
          r = '0;
          r.woken_valid = 1'b1;
          r.woken_waiter = woken[k];
          r.top_valid = tv;
          r.top_priority = tp;
          r.last = (k == woken.size() - 1);
          pending.push_back(r);
        end
      end
    endfunction

    function automatic void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        report("result word with nothing expected", got, '0);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) report("result word mismatch", got, exp_w);
    endfunction

    function automatic void report(string what, out_word_t got, out_word_t exp_w);
      $display("ERROR %s: got %h expected %h", what, got, exp_w);
      errors++;
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  wait_scoreboard sb = new();
  bit quiet;   // long stretch with no idling on either side

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  event_waiter_table u_dut (.*);

  // receiver: random stall, checks every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_data_o);
    out_stall_i <= !quiet && ($urandom_range(99) < 15);
  end

  // send one word, with a random idle gap before it
  task automatic send_word(in_word_t w);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  task automatic send_op(op_t op, int o, int w, int p, logic [31:0] ev);
    in_word_t x;
    x.op = op;
    x.owner = 4'(o);
    x.waiter = 4'(w);
    x.priority_req = 8'(p);
    x.events = ev;
    send_word(x);
  endtask

  initial begin
    int o;
    int r;
    quiet = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty owner ops, signal with nobody waiting, undefined op
    send_op(OP_SIGNAL, 0, 0, 0, 32'hffff_ffff);
    send_op(OP_REMOVE, 0, 3, 0, 0);
    send_op(OP_NONE, 0, 0, 0, 0);
    // fill owner 15 with equal and mixed priorities, then a duplicate on a full table
    for (int i = 0; i < WAITERS; i++)
      send_op(OP_ADD, 15, i, (i % 3 == 0) ? 8'hff : i * 7, 32'h1 << i);
    send_op(OP_ADD, 15, 4, 0, 0);
    send_op(OP_ADD, 0, 15, 0, 32'h8000_0000);
    send_op(OP_REMOVE, 15, 0, 0, 0);
    send_op(OP_ADD, 15, 0, 8'h00, 32'hffff_ffff);
    // owner 15 is full again
    send_op(OP_SIGNAL, 15, 0, 0, 32'hffff_ffff);   // wakes all sixteen
    send_op(OP_SIGNAL, 0, 0, 0, 32'h7fff_ffff);    // mask misses

    // random: a few owners so tables get deep and sometimes full
    for (int n = 0; n < 100; n++) begin
      if (n == 40) quiet = 1'b1;
      if (n == 70) quiet = 1'b0;
      o = (n % 20 == 0) ? 15 : $urandom_range(3);
      r = $urandom_range(99);
      if (r < 55)
        send_op(OP_ADD, o, $urandom_range(15), $urandom_range(255),
                ($urandom_range(3) == 0) ? $urandom : (32'h1 << $urandom_range(31)));
      else if (r < 75)
        send_op(OP_REMOVE, o, $urandom_range(15), $urandom_range(255), $urandom);
      else if (r < 97)
        send_op(OP_SIGNAL, o, $urandom_range(15), $urandom_range(255),
                ($urandom_range(1) == 1) ? $urandom : (32'h1 << $urandom_range(31)));
      else
        send_op(OP_NONE, o, $urandom_range(15), $urandom_range(255), $urandom);
    end
    in_valid_i <= 1'b0;

    // drain and let the block settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
